@@ hw/rtl/nfcp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// nfcp_pkg
// Shared types and constants for the navigation frame CRC parser.
// ---------------------------------------------------------------------------
package nfcp_pkg;

	localparam int unsigned POS_W      = 6;
	localparam int unsigned PEND_W     = 288;	// frame bytes 6..41

	localparam logic [POS_W-1:0] POS_CRC_FIRST = POS_W'(1);
	localparam logic [POS_W-1:0] POS_FIELD_FIRST = POS_W'(6);
	localparam logic [POS_W-1:0] POS_CRC_LAST  = POS_W'(41);
	localparam logic [POS_W-1:0] POS_CRC_HI    = POS_W'(42);
	localparam logic [POS_W-1:0] POS_CRC_LO    = POS_W'(43);

	localparam logic [7:0]  DEFAULT_SYNC = 8'hFA;
	localparam logic [15:0] CRC_POLY     = 16'h1021;

	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_IDLE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr;
		logic en;
		logic din;
	} crc_ctl_t;

endpackage : nfcp_pkg
`default_nettype wire

@@ hw/rtl/nav_frame_crc_parser_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// nav_frame_crc_parser_top
// Builds 44-byte navigation frames, checks sync and CRC-16, holds last good
// attitude and position words.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | action, data_byte
//  out      | out_valid / out_ready  | frame_ok, yaw/pitch/roll_bits,
//           |                        | latitude/longitude/altitude_bits
//  cfg      | sync_we                | sync_wdata
//
//  A data byte at positions 1..41 is accepted, then shifted bit by bit
//  through the serial CRC loop; other data bytes are taken on accept. A
//  line-idle request pads CRC and fields with zero bytes from max(p,1)
//  through position 41 (none once p passes 41), p being bytes taken so far.
//  Reset clears frame state and held values; sync resets to 0xFA. Data
//  requests go on while a result waits; an idle request waits in finish.
// ---------------------------------------------------------------------------
module nav_frame_crc_parser_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         action,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        frame_ok,
	output logic [31:0] yaw_bits,
	output logic [31:0] pitch_bits,
	output logic [31:0] roll_bits,
	output logic [63:0] latitude_bits,
	output logic [63:0] longitude_bits,
	output logic [63:0] altitude_bits,
	input  wire         sync_we,
	input  wire  [7:0]  sync_wdata
);
	import nfcp_pkg::*;

	state_t                  state_q, state_d;
	logic [POS_W-1:0]        pos_q;
	logic [2:0]              bit_cnt_q;
	logic [7:0]              byte_q;
	logic                    pad_q;
	logic                    sync_match_q;
	logic [15:0]             rx_crc_q;
	logic [7:0]              sync_q;
	logic [PEND_W-1:0]       pend_q;
	logic [PEND_W-1:0]       good_q;
	logic                    out_valid_q;
	logic                    frame_ok_q;
	logic [15:0]             crc;
	crc_ctl_t                crc_ctl;
	logic                    accept;
	logic                    finish_go;
	logic                    last_bit;
	logic                    frame_good;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid & in_ready;
	assign last_bit   = (bit_cnt_q == 3'd7);
	assign frame_good = sync_match_q && (crc == rx_crc_q);

	nfcp_crc_serial u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		finish_go   = 1'b0;
		crc_ctl.clr = 1'b0;
		crc_ctl.en  = 1'b0;
		crc_ctl.din = byte_q[~bit_cnt_q];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_IDLE) begin
						state_d = (pos_q > POS_CRC_LAST) ? ST_FINISH : ST_SHIFT;
					end else if (pos_q >= POS_CRC_FIRST && pos_q <= POS_CRC_LAST) begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				crc_ctl.en = 1'b1;
				if (last_bit) begin
					if (!pad_q) begin
						state_d = ST_IDLE;
					end else if (pos_q >= POS_CRC_LAST) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					finish_go   = 1'b1;
					crc_ctl.clr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			bit_cnt_q    <= '0;
			pad_q        <= 1'b0;
			sync_match_q <= 1'b0;
			rx_crc_q     <= '0;
			sync_q       <= DEFAULT_SYNC;
			good_q       <= '0;
			out_valid_q  <= 1'b0;
			frame_ok_q   <= 1'b0;
		end else begin
			if (sync_we) begin
				sync_q <= sync_wdata;
			end
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					bit_cnt_q <= '0;
					if (accept) begin
						if (action == ACT_IDLE) begin
							pad_q <= 1'b1;
							if (pos_q == '0) begin
								// empty frame: byte 0 counts as zero
								sync_match_q <= (sync_q == 8'h00);
								pos_q        <= POS_CRC_FIRST;
							end
						end else if (pos_q == '0) begin
							sync_match_q <= (data_byte == sync_q);
							pos_q        <= POS_CRC_FIRST;
						end else if (pos_q <= POS_CRC_LAST) begin
							pad_q <= 1'b0;
						end else if (pos_q == POS_CRC_HI) begin
							rx_crc_q[15:8] <= data_byte;
							pos_q          <= pos_q + POS_W'(1);
						end else if (pos_q == POS_CRC_LO) begin
							rx_crc_q[7:0] <= data_byte;
							pos_q         <= pos_q + POS_W'(1);
						end
					end
				end
				ST_SHIFT: begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (last_bit) begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						frame_ok_q   <= frame_good;
						if (frame_good) begin
							good_q <= pend_q;
						end
						pos_q        <= '0;
						pad_q        <= 1'b0;
						sync_match_q <= 1'b0;
						rx_crc_q     <= '0;
					end
				end
				default: begin
					bit_cnt_q <= '0;
				end
			endcase
		end
	end

	// Payload: byte under test and the field shift register. Fields enter
	// LSB first at the top, so byte 6 lands at bit 0 after 36 bytes.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			byte_q <= (action == ACT_IDLE) ? 8'h00 : data_byte;
		end
		if (state_q == ST_SHIFT && pos_q >= POS_FIELD_FIRST) begin
			pend_q <= {byte_q[bit_cnt_q], pend_q[PEND_W-1:1]};
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_ok       = frame_ok_q;
	assign yaw_bits       = good_q[31:0];
	assign pitch_bits     = good_q[63:32];
	assign roll_bits      = good_q[95:64];
	assign latitude_bits  = good_q[159:96];
	assign longitude_bits = good_q[223:160];
	assign altitude_bits  = good_q[287:224];

endmodule : nav_frame_crc_parser_top
`default_nettype wire

@@ hw/rtl/nfcp_crc_serial.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// nfcp_crc_serial
// Bit-serial CRC-16 (poly 0x1021, init 0), one bit per enabled cycle, MSB first.
// ---------------------------------------------------------------------------
module nfcp_crc_serial (
	input  wire                 clk,
	input  wire                 arst_n,
	input  nfcp_pkg::crc_ctl_t  ctl,
	output logic [15:0]         crc
);
	import nfcp_pkg::*;

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (ctl.clr) begin
			crc_q <= '0;
		end else if (ctl.en) begin
			crc_q <= {crc_q[14:0], 1'b0} ^ ((crc_q[15] ^ ctl.din) ? CRC_POLY : 16'h0000);
		end
	end

	assign crc = crc_q;

endmodule : nfcp_crc_serial
`default_nettype wire

@@ verif/nav_frame_crc_parser_top_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nav_frame_crc_parser_top_tb
// Feeds serial bytes and line-idle requests to the frame parser and checks every
// report against an in-bench model of the frame store, the CRC-16 and the held
// attitude/position words, or against a typed result on marked directed rows. A short
// table of directed frames comes first, then random frames (over half well formed,
// most with a valid CRC) under several sync values and handshake stall patterns.
// ---------------------------------------------------------------------------
module nav_frame_crc_parser_top_tb;
	import nfcp_pkg::*;

	localparam int FRAME_BYTES = int'(POS_CRC_LO) + 1;
	localparam int ANGLE_END   = int'(POS_FIELD_FIRST) + 12;	// bytes 6..17
	localparam int PHASE_ITEMS = 260;
	localparam int SETTLE_CYC  = 20;
	localparam int TAIL_CYC    = 400;

	typedef struct packed {
		logic        ok;
		logic [31:0] yaw;
		logic [31:0] pitch;
		logic [31:0] roll;
		logic [63:0] lat;
		logic [63:0] lon;
		logic [63:0] alt;
	} nav_report_t;

	typedef enum logic {ROW_REQ, ROW_SYNC} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic       act;
		logic [7:0] dat;	// data byte, or sync value on a ROW_SYNC row
		logic       typed;
		logic       ok;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = ACT_DATA;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        frame_ok;
	logic [31:0] yaw_bits;
	logic [31:0] pitch_bits;
	logic [31:0] roll_bits;
	logic [63:0] latitude_bits;
	logic [63:0] longitude_bits;
	logic [63:0] altitude_bits;
	logic        sync_we = 1'b0;
	logic [7:0]  sync_wdata = 8'h00;

	nav_frame_crc_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_ok      (frame_ok),
		.yaw_bits      (yaw_bits),
		.pitch_bits    (pitch_bits),
		.roll_bits     (roll_bits),
		.latitude_bits (latitude_bits),
		.longitude_bits(longitude_bits),
		.altitude_bits (altitude_bits),
		.sync_we       (sync_we),
		.sync_wdata    (sync_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// frame model state
	logic [7:0]  sync_held = DEFAULT_SYNC;
	int          frame_pos = 0;
	logic [15:0] frame_crc = '0;
	logic        sync_hit = 1'b0;
	logic [15:0] rx_crc = '0;
	logic [31:0] pend_ang [3] = '{default: '0};
	logic [63:0] pend_pos [3] = '{default: '0};
	logic [31:0] held_ang [3] = '{default: '0};
	logic [63:0] held_pos [3] = '{default: '0};

	nav_report_t awaited_reports [$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	// MSB-first CRC-16 with the CCITT polynomial 0x1021, one byte
	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	// Advances the frame model by one request; returns 1 when a report is due.
	function automatic logic nav_frame_update(input logic act, input logic [7:0] dat,
			output nav_report_t rpt);
		int          p;
		int          k;
		logic [15:0] c;
		logic        hit;
		rpt = '0;
		if (act == ACT_DATA) begin
			p = frame_pos;
			if (p < FRAME_BYTES) begin
				if (p == 0) begin
					sync_hit = (dat == sync_held);
				end else if (p <= int'(POS_CRC_LAST)) begin
					frame_crc = crc_step(frame_crc, dat);
					if (p >= int'(POS_FIELD_FIRST) && p < ANGLE_END) begin
						k = (p - int'(POS_FIELD_FIRST)) / 4;
						pend_ang[k][8*((p - int'(POS_FIELD_FIRST)) % 4) +: 8] = dat;
					end else if (p >= ANGLE_END) begin
						k = (p - ANGLE_END) / 8;
						pend_pos[k][8*((p - ANGLE_END) % 8) +: 8] = dat;
					end
				end else if (p == int'(POS_CRC_HI)) begin
					rx_crc[15:8] = dat;
				end else begin
					rx_crc[7:0] = dat;
				end
				frame_pos = p + 1;
			end
			return 1'b0;
		end
		// missing bytes up to the last CRC byte count as zero
		c = frame_crc;
		for (p = (frame_pos < 1) ? 1 : frame_pos; p <= int'(POS_CRC_LAST); p++)
			c = crc_step(c, 8'h00);
		hit = (frame_pos == 0) ? (sync_held == 8'h00) : sync_hit;
		rpt.ok = hit && (c == rx_crc);
		if (rpt.ok) begin
			held_ang = pend_ang;
			held_pos = pend_pos;
		end
		rpt.yaw   = held_ang[0];
		rpt.pitch = held_ang[1];
		rpt.roll  = held_ang[2];
		rpt.lat   = held_pos[0];
		rpt.lon   = held_pos[1];
		rpt.alt   = held_pos[2];
		frame_pos = 0;
		frame_crc = '0;
		sync_hit  = 1'b0;
		rx_crc    = '0;
		pend_ang  = '{default: '0};
		pend_pos  = '{default: '0};
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// report sink with random back-pressure
	always @(posedge clk) begin
		nav_report_t want;
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual frame_ok %b",
					$time, frame_ok);
				mismatches++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("frame_ok", 64'(want.ok), 64'(frame_ok));
				check_field("yaw_bits", 64'(want.yaw), 64'(yaw_bits));
				check_field("pitch_bits", 64'(want.pitch), 64'(pitch_bits));
				check_field("roll_bits", 64'(want.roll), 64'(roll_bits));
				check_field("latitude_bits", want.lat, latitude_bits);
				check_field("longitude_bits", want.lon, longitude_bits);
				check_field("altitude_bits", want.alt, altitude_bits);
			end
		end
	end

	// One request; a typed expectation replaces the model's on directed rows marked typed.
	task automatic send_request(input logic act, input logic [7:0] dat,
			input logic use_typed, input logic typed_ok);
		nav_report_t rpt;
		nav_report_t typed_rpt;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		data_byte <= dat;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (nav_frame_update(act, dat, rpt)) begin
			typed_rpt = '0;
			typed_rpt.ok = typed_ok;
			awaited_reports.push_back(use_typed ? typed_rpt : rpt);
		end
	endtask

	// Lets every awaited report drain, then settles so a byte in flight can finish.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] val);
		quiesce();
		sync_we    <= 1'b1;
		sync_wdata <= val;
		@(posedge clk);
		sync_we   <= 1'b0;
		sync_held  = val;
	endtask

	task automatic send_frame();
		logic [7:0]  fb [0:49];
		int          len;
		int          kind;
		int          i;
		logic        zero_fill;
		logic [15:0] c;
		kind = $urandom_range(99);
		if (kind < 55) begin
			// well formed: sync, random payload, matching CRC
			fb[0] = sync_held;
			c = '0;
			for (i = 1; i <= int'(POS_CRC_LAST); i++) begin
				fb[i] = 8'($urandom_range(255));
				c = crc_step(c, fb[i]);
			end
			fb[int'(POS_CRC_HI)] = c[15:8];
			fb[int'(POS_CRC_LO)] = c[7:0];
			len = FRAME_BYTES;
			if ($urandom_range(9) == 0)
				fb[$urandom_range(FRAME_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
			if ($urandom_range(5) == 0) begin
				len = FRAME_BYTES + $urandom_range(1, 5);
				for (i = FRAME_BYTES; i < len; i++)
					fb[i] = 8'($urandom_range(255));
			end
		end else if (kind < 85) begin
			// short frame, often zero filled so the padded CRC still holds
			len = $urandom_range(0, 12);
			zero_fill = 1'($urandom_range(1));
			fb[0] = $urandom_range(1) ? sync_held : 8'($urandom_range(255));
			for (i = 1; i < len; i++)
				fb[i] = zero_fill ? 8'h00 : 8'($urandom_range(255));
		end else begin
			len = $urandom_range(0, 50);
			for (i = 0; i < len; i++)
				fb[i] = 8'($urandom_range(255));
		end
		for (i = 0; i < len; i++)
			send_request(ACT_DATA, fb[i], 1'b0, 1'b0);
		send_request(ACT_IDLE, 8'($urandom_range(255)), 1'b0, 1'b0);
		if ($urandom_range(19) == 0)
			quiesce();
	endtask

	// Held values stay zero through these rows, so typed reports carry zeros.
	dir_row_t dir_rows [0:20] = '{
		'{ROW_REQ,  ACT_IDLE, 8'h00, 1'b1, 1'b0},	// empty frame, sync nonzero
		'{ROW_REQ,  ACT_DATA, 8'hFA, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_IDLE, 8'hFF, 1'b1, 1'b1},	// sync only, zero padding
		'{ROW_REQ,  ACT_DATA, 8'h00, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_IDLE, 8'h00, 1'b1, 1'b0},
		'{ROW_REQ,  ACT_DATA, 8'hFF, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_IDLE, 8'h00, 1'b1, 1'b0},
		'{ROW_REQ,  ACT_DATA, 8'hFA, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_DATA, 8'h00, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_DATA, 8'h00, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_IDLE, 8'h00, 1'b1, 1'b1},
		'{ROW_REQ,  ACT_DATA, 8'hFA, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_DATA, 8'h01, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_DATA, 8'hFF, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_IDLE, 8'h00, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_DATA, 8'hFA, 1'b0, 1'b0},
		'{ROW_SYNC, ACT_DATA, 8'h11, 1'b0, 1'b0},	// sync changes mid-frame
		'{ROW_REQ,  ACT_IDLE, 8'h00, 1'b1, 1'b1},
		'{ROW_REQ,  ACT_IDLE, 8'h00, 1'b1, 1'b0},
		'{ROW_SYNC, ACT_DATA, 8'h00, 1'b0, 1'b0},
		'{ROW_REQ,  ACT_IDLE, 8'h00, 1'b1, 1'b1}	// empty frame, zero sync
	};

	initial begin
		int unsigned phase_end;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_SYNC)
				write_sync(dir_rows[r].dat);
			else
				send_request(dir_rows[r].act, dir_rows[r].dat, dir_rows[r].typed,
					dir_rows[r].ok);
		end
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_sync(DEFAULT_SYNC);
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					write_sync(8'h00);
					send_idle_pct  = 87;
					recv_stall_pct = 0;
				end
				2: begin
					write_sync(8'hFF);
					send_idle_pct  = 0;
					recv_stall_pct = 87;
				end
				3: begin
					write_sync(8'($urandom_range(255)));
					send_idle_pct  = 10;
					recv_stall_pct = 10;
				end
				default: begin
					write_sync(8'($urandom_range(255)));
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_frame();
		end
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (mismatches == 0 && awaited_reports.size() == 0) begin
			$display("nav_frame_crc_parser_top_tb passed");
		end else begin
			$display("nav_frame_crc_parser_top_tb failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("nav_frame_crc_parser_top_tb failed");
		$finish;
	end

endmodule

@@ nav_frame_crc_parser_top.f @@
hw/rtl/nfcp_pkg.sv
hw/rtl/nfcp_crc_serial.sv
hw/rtl/nav_frame_crc_parser_top.sv
verif/nav_frame_crc_parser_top_tb.sv
